/* hdl/sct_pkg.sv */
// Shared types and constants for the sine, cosine and tangent unit.
// Holds the fixed-point polynomial constants, opcodes and pipeline side data.
// Depends on nothing.
`timescale 1ns / 1ps

package sct_pkg;

    localparam int FRACTION_BITS_DEF = 16;

    // Magnitude width of the Q1.30 sine and cosine terms fed to the divider.
    localparam int MAG_W = 31;

    localparam logic [31:0] TWO_OVER_PI_Q32 = 32'd2734261102;
    localparam logic [27:0] POLY_C0         = 28'd243237849;
    localparam logic [30:0] POLY_C1         = 31'd1075570192;
    localparam logic [32:0] POLY_C2         = 33'd4729845942;
    localparam logic [31:0] ONE_Q30         = 32'h4000_0000;
    localparam logic [63:0] HALF_Q30        = 64'h0000_0000_2000_0000;

    localparam logic [31:0] VALUE_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] VALUE_MIN = 32'h8000_0000;

    typedef enum logic [1:0] {
        OP_SIN = 2'd0,
        OP_COS = 2'd1,
        OP_TAN = 2'd2
    } op_t;

    typedef struct packed {
        logic [1:0]  op;
        logic        tan_neg;
        logic        cos_zero;
        logic        sin_neg;
        logic [31:0] res_sc;
    } side_t;

endpackage

/* hdl/sine_cosine_tangent_approx_top.sv */
// Top level of the pipelined sine, cosine and tangent unit.
// Evaluates the quarter-turn polynomial in two lanes and divides them for tangent.
// Depends on sct_pkg.
`timescale 1ns / 1ps

// Usage: a request is taken at every rising edge where start is high; busy is
// always low, so a new opcode and angle may be presented in every cycle.
// Opcode 0 gives the sine, 1 the cosine and 2 the tangent of the angle in
// radians, signed fixed point with FRACTION_BITS fraction bits. Opcode 3
// returns zero. Each request produces exactly one result: done is high for
// one cycle with value and divide_fault, in request order. divide_fault is set
// only for a tangent whose cosine term is zero, with value saturated.
// Results pass the front stages, the divider input stage, the divider stages
// and the output register in that order; throughput is one request
// per cycle. Nine stages carry the angle scaling and the two polynomial
// lanes, then a restoring divider retires one quotient bit per stage, which
// sets the depth. Every request goes through the divider stages so that
// results leave in order. The receiver cannot stall, so nothing is ever held.
// Reset clears all valid bits; requests in flight are dropped and no result
// is produced for them.
module sine_cosine_tangent_approx_top #(
    parameter int FRACTION_BITS = sct_pkg::FRACTION_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         opcode,
    input  logic signed [31:0] angle,
    output logic               done,
    output logic signed [31:0] value,
    output logic               divide_fault
);

    import sct_pkg::*;

    localparam int SH  = 30 - FRACTION_BITS;
    localparam int DW  = MAG_W + FRACTION_BITS;
    localparam int LAT = 11 + DW;
    localparam logic signed [31:0] HALF_LSB = 32'sd1 <<< (SH - 1);

    // Front stages 1 to 9: valid and opcode line.
    logic       fv_reg  [1:9];
    logic [1:0] fop_reg [1:9];

    logic signed [64:0] ang_prod;
    logic [31:0]        q_reg;

    logic [31:0]        qx         [2];
    logic signed [30:0] y_reg      [2];
    logic               neg_reg    [2][2:8];
    logic signed [61:0] ysq        [2];
    logic [30:0]        y2_reg     [2];
    logic [30:0]        d1_reg     [2];
    logic [32:0]        d2_reg     [2][4:6];
    logic [58:0]        p1_reg     [2];
    logic [59:0]        p1_sum     [2];
    logic [29:0]        r_reg      [2];
    logic [62:0]        p2_reg     [2];
    logic [63:0]        p2_sum     [2];
    logic [30:0]        mag_reg    [2];
    logic signed [31:0] s_reg      [2];
    logic signed [31:0] sc_round   [2];

    // Divider line; index 0 is the divider input stage.
    logic              dv_reg    [0:DW];
    side_t             dside_reg [0:DW];
    logic [MAG_W-1:0]  drem_reg  [0:DW];
    logic [DW-1:0]     dwork_reg [0:DW];
    logic [MAG_W-1:0]  dden_reg  [0:DW];

    side_t             side_next;
    logic [MAG_W-1:0]  sin_abs;
    logic [MAG_W-1:0]  cos_abs;

    logic              done_reg;
    logic [31:0]       value_reg;
    logic              fault_reg;
    logic [31:0]       value_next;
    logic              fault_next;
    logic              quo_hi;
    logic [DW-1:0]     quo;

    assign busy = 1'b0;

    always_comb
    begin
        ang_prod = angle * $signed({1'b0, TWO_OVER_PI_Q32});
        qx[0]    = q_reg;
        qx[1]    = q_reg + ONE_Q30;
        for (int l = 0; l < 2; l++)
        begin
            ysq[l]      = y_reg[l] * y_reg[l];
            p1_sum[l]   = {1'b0, p1_reg[l]} + HALF_Q30[59:0];
            p2_sum[l]   = {1'b0, p2_reg[l]} + HALF_Q30;
            sc_round[l] = (s_reg[l] + HALF_LSB) >>> SH;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= 9; k++)
            begin
                fv_reg[k] <= 1'b0;
            end
        end
        else
        begin
            fv_reg[1] <= start && !busy;
            for (int k = 2; k <= 9; k++)
            begin
                fv_reg[k] <= fv_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fop_reg[1] <= opcode;
        for (int k = 2; k <= 9; k++)
        begin
            fop_reg[k] <= fop_reg[k-1];
        end
        q_reg <= ang_prod[FRACTION_BITS+2 +: 32];
        for (int l = 0; l < 2; l++)
        begin
            y_reg[l]      <= $signed({~qx[l][30], qx[l][29:0]});
            neg_reg[l][2] <= qx[l][31];
            for (int k = 3; k <= 8; k++)
            begin
                neg_reg[l][k] <= neg_reg[l][k-1];
            end
            y2_reg[l]    <= ysq[l][60:30];
            d1_reg[l]    <= POLY_C1 - y2_reg[l];
            d2_reg[l][4] <= POLY_C2 - {2'b00, y2_reg[l]};
            d2_reg[l][5] <= d2_reg[l][4];
            d2_reg[l][6] <= d2_reg[l][5];
            p1_reg[l]    <= POLY_C0 * d1_reg[l];
            r_reg[l]     <= p1_sum[l][59:30];
            p2_reg[l]    <= r_reg[l] * d2_reg[l][6];
            mag_reg[l]   <= p2_sum[l][60:30];
            s_reg[l]     <= neg_reg[l][8] ? -$signed({1'b0, mag_reg[l]})
                                          : $signed({1'b0, mag_reg[l]});
        end
    end

    always_comb
    begin
        sin_abs = s_reg[0][31] ? MAG_W'(-s_reg[0]) : MAG_W'(s_reg[0]);
        cos_abs = s_reg[1][31] ? MAG_W'(-s_reg[1]) : MAG_W'(s_reg[1]);
        side_next.op       = fop_reg[9];
        side_next.tan_neg  = s_reg[0][31] ^ s_reg[1][31];
        side_next.cos_zero = (s_reg[1] == 32'sd0);
        side_next.sin_neg  = s_reg[0][31];
        case (fop_reg[9])
            OP_SIN:  side_next.res_sc = sc_round[0];
            OP_COS:  side_next.res_sc = sc_round[1];
            default: side_next.res_sc = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg[0] <= 1'b0;
        end
        else
        begin
            dv_reg[0] <= fv_reg[9];
        end
    end

    always_ff @(posedge clk)
    begin
        dside_reg[0] <= side_next;
        drem_reg[0]  <= '0;
        dwork_reg[0] <= {sin_abs, {FRACTION_BITS{1'b0}}};
        dden_reg[0]  <= cos_abs;
    end

    for (genvar i = 1; i <= DW; i++)
    begin : g_div
        logic [MAG_W:0] trial;
        logic [MAG_W:0] diff;
        logic           ge;

        always_comb
        begin
            trial = {drem_reg[i-1], dwork_reg[i-1][DW-1]};
            diff  = trial - {1'b0, dden_reg[i-1]};
            ge    = (trial >= {1'b0, dden_reg[i-1]});
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[i] <= 1'b0;
            end
            else
            begin
                dv_reg[i] <= dv_reg[i-1];
            end
        end

        always_ff @(posedge clk)
        begin
            dside_reg[i] <= dside_reg[i-1];
            dden_reg[i]  <= dden_reg[i-1];
            drem_reg[i]  <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
            dwork_reg[i] <= {dwork_reg[i-1][DW-2:0], ge};
        end
    end

    always_comb
    begin
        quo        = dwork_reg[DW];
        quo_hi     = (quo[DW-1:31] != '0);
        value_next = dside_reg[DW].res_sc;
        fault_next = 1'b0;
        case (dside_reg[DW].op)
            OP_TAN:
            begin
                if (dside_reg[DW].cos_zero)
                begin
                    fault_next = 1'b1;
                    value_next = dside_reg[DW].sin_neg ? VALUE_MIN : VALUE_MAX;
                end
                else if (dside_reg[DW].tan_neg)
                begin
                    value_next = quo_hi ? VALUE_MIN : -quo[31:0];
                end
                else
                begin
                    value_next = quo_hi ? VALUE_MAX : quo[31:0];
                end
            end
            default:
            begin
                value_next = dside_reg[DW].res_sc;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_reg[DW];
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        fault_reg <= fault_next;
    end

    assign done         = done_reg;
    assign value        = $signed(value_reg);
    assign divide_fault = fault_reg;

    // Every accepted request yields a result after the fixed latency.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("missing result after accepted request");

    // No result appears without a request accepted the fixed latency earlier.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##LAT !done)
        else $error("result without request");

    // Only a tangent can raise the divide fault.
    a_fault_tan_only: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_reg[DW] && (dside_reg[DW].op != OP_TAN)) |=> !divide_fault)
        else $error("divide fault on sine or cosine");

    // A divide fault always comes with a saturated value.
    a_fault_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        (done && divide_fault) |-> (value_reg == VALUE_MAX || value_reg == VALUE_MIN))
        else $error("divide fault without saturated value");

endmodule

/* tb/tb_sine_cosine_tangent_approx_top.sv */
// Self-checking testbench for the pipelined sine, cosine and tangent unit.
// Predicts each request in fixed point and compares every result in order.
// Depends on sct_pkg and sine_cosine_tangent_approx_top.
`timescale 1ns / 1ps

module tb_sine_cosine_tangent_approx_top;
    import sct_pkg::*;

    localparam int FB = FRACTION_BITS_DEF;
    localparam int LATENCY = 11 + 31 + FB;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int HALF_PI = int'(1.5707963268 * (2.0 ** FB));
    localparam int SPAN = 8 * HALF_PI;

    localparam longint K_TWO_OVER_PI = TWO_OVER_PI_Q32;
    localparam longint K_C0 = POLY_C0;
    localparam longint K_C1 = POLY_C1;
    localparam longint K_C2 = POLY_C2;
    localparam longint K_ONE = ONE_Q30;
    localparam longint K_HALF = HALF_Q30;
    localparam longint K_MAX = 64'sd2147483647;
    localparam longint K_MIN = -64'sd2147483648;

    typedef struct {
        logic signed [31:0] value;
        logic               fault;
    } trig_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [1:0]         opcode = OP_SIN;
    logic signed [31:0] angle = '0;
    logic               busy;
    logic               done;
    logic signed [31:0] value;
    logic               divide_fault;

    trig_result_t pending_results[$];
    int           errors = 0;
    int           cycle_count = 0;
    bit           use_gaps = 1'b1;

    sine_cosine_tangent_approx_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .angle        (angle),
        .done         (done),
        .value        (value),
        .divide_fault (divide_fault)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Sine polynomial of a quarter-turn count with 30 fraction bits, result Q1.30.
    function automatic longint quarter_poly(longint q);
        longint y;
        longint y2;
        longint r;
        longint mag;
        y = longint'({33'd0, q[30:0]}) - K_ONE;
        y2 = (y * y) >>> 30;
        r = (K_C0 * (K_C1 - y2) + K_HALF) >>> 30;
        mag = (r * (K_C2 - y2) + K_HALF) >>> 30;
        return q[31] ? -mag : mag;
    endfunction

    function automatic longint to_fixed(longint s);
        int sh;
        sh = 30 - FB;
        return (s + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic trig_result_t predict_trig(logic [1:0] op, logic signed [31:0] ang);
        longint q;
        longint sn;
        longint cs;
        longint quo;
        trig_result_t res;
        q = (longint'(ang) * K_TWO_OVER_PI) >>> (FB + 2);
        res.value = '0;
        res.fault = 1'b0;
        case (op)
            OP_SIN: res.value = 32'(to_fixed(quarter_poly(q)));
            OP_COS: res.value = 32'(to_fixed(quarter_poly(q + K_ONE)));
            OP_TAN:
            begin
                sn = quarter_poly(q);
                cs = quarter_poly(q + K_ONE);
                if (cs == 0)
                begin
                    res.fault = 1'b1;
                    res.value = (sn >= 0) ? VALUE_MAX : VALUE_MIN;
                end
                else
                begin
                    quo = (sn * (longint'(1) <<< FB)) / cs;
                    if (quo > K_MAX)
                        quo = K_MAX;
                    else if (quo < K_MIN)
                        quo = K_MIN;
                    res.value = 32'(quo);
                end
            end
            default: res.value = '0;
        endcase
        return res;
    endfunction

    always @(posedge clk)
    begin
        trig_result_t want;
        if (rst_n && start && !busy)
            pending_results.push_back(predict_trig(opcode, angle));
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request outstanding: value %0d, divide_fault %0b",
                       value, divide_fault);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (value !== want.value)
                begin
                    $error("value: expected %0d, actual %0d", want.value, value);
                    errors++;
                end
                if (divide_fault !== want.fault)
                begin
                    $error("divide_fault: expected %0b, actual %0b", want.fault, divide_fault);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("sine_cosine_tangent_approx_top: mismatch");
            $finish;
        end
    end

    task automatic send_request(input logic [1:0] op, input logic signed [31:0] ang);
        int gap;
        gap = use_gaps ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start  <= 1'b1;
        opcode <= op;
        angle  <= ang;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [1:0] random_op();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 3)
            return OP_SIN;
        else if (sel < 6)
            return OP_COS;
        else if (sel < 9)
            return OP_TAN;
        return OP_UNUSED;
    endfunction

    // Mostly a few turns around zero, some full-range words, some near the axes.
    function automatic logic signed [31:0] random_angle();
        int sel;
        int k;
        sel = $urandom_range(0, 19);
        if (sel < 11)
            return int'($urandom_range(0, 2 * SPAN)) - SPAN;
        if (sel < 16)
            return $urandom;
        k = int'($urandom_range(0, 40)) - 20;
        return k * HALF_PI + int'($urandom_range(0, 64)) - 32;
    endfunction

    task automatic test_zero_angle();
        use_gaps = 1'b1;
        send_request(OP_SIN, '0);
        send_request(OP_COS, '0);
        send_request(OP_TAN, '0);
        send_request(OP_UNUSED, '0);
    endtask

    task automatic test_angle_extremes();
        use_gaps = 1'b1;
        send_request(OP_SIN, 32'sh7FFF_FFFF);
        send_request(OP_COS, 32'sh7FFF_FFFF);
        send_request(OP_TAN, 32'sh7FFF_FFFF);
        send_request(OP_SIN, 32'sh8000_0000);
        send_request(OP_COS, 32'sh8000_0000);
        send_request(OP_TAN, 32'sh8000_0000);
        send_request(OP_TAN, 32'sd1);
        send_request(OP_TAN, -32'sd1);
    endtask

    // Tangent near odd quarter turns has the smallest cosine the polynomial can give.
    task automatic test_quarter_turns();
        use_gaps = 1'b1;
        send_request(OP_SIN, HALF_PI);
        send_request(OP_COS, HALF_PI);
        send_request(OP_TAN, HALF_PI);
        send_request(OP_TAN, HALF_PI - 1);
        send_request(OP_TAN, -HALF_PI);
        send_request(OP_SIN, 2 * HALF_PI);
        send_request(OP_COS, 2 * HALF_PI);
        send_request(OP_TAN, 3 * HALF_PI);
        send_request(OP_SIN, -3 * HALF_PI);
        send_request(OP_COS, 4 * HALF_PI);
    endtask

    task automatic test_unused_opcode();
        use_gaps = 1'b1;
        send_request(OP_UNUSED, 32'sh7FFF_FFFF);
        send_request(OP_UNUSED, 32'sh8000_0000);
        send_request(OP_UNUSED, random_angle());
    endtask

    task automatic test_random_mix(input int count, input bit gaps);
        use_gaps = gaps;
        for (int k = 0; k < count; k++)
            send_request(random_op(), random_angle());
    endtask

    task automatic test_pause_until_drained();
        test_random_mix(20, 1'b0);
        wait_drained();
        test_random_mix(20, 1'b1);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_zero_angle();
        test_angle_extremes();
        test_quarter_turns();
        test_unused_opcode();
        test_random_mix(500, 1'b1);
        test_random_mix(200, 1'b0);
        test_pause_until_drained();
        test_random_mix(260, 1'b1);
        wait_drained();
        repeat (LATENCY + 8) @(posedge clk);
        if (errors == 0)
            $display("sine_cosine_tangent_approx_top: match");
        else
            $display("sine_cosine_tangent_approx_top: mismatch");
        $finish;
    end

endmodule
